FILE: rtl/core/smd_pkg.sv
// Constants, codes and types shared by the slot memory decoder.
package smd_pkg;

  localparam int AddrW    = 16;
  localparam int DataW    = 8;
  localparam int RamBytes = 65536;
  localparam int RomBytes = 65536;
  localparam int RamAw    = $clog2(RamBytes);
  localparam int RomAw    = $clog2(RomBytes);
  localparam int ClrDepth = (RamBytes > RomBytes) ? RamBytes : RomBytes;
  localparam int ClrW     = $clog2(ClrDepth);

  localparam logic [AddrW:0]     RamLimit    = (AddrW + 1)'(RamBytes);
  localparam logic [AddrW:0]     RomLimit    = (AddrW + 1)'(RomBytes);
  localparam logic [ClrW:0]      RamClrLimit = (ClrW + 1)'(RamBytes);
  localparam logic [ClrW:0]      RomClrLimit = (ClrW + 1)'(RomBytes);
  localparam logic [ClrW-1:0]    ClrLast     = ClrW'(ClrDepth - 1);

  localparam logic [AddrW-1:0]   SecRegAddr  = 16'hFFFF;
  localparam logic [DataW-1:0]   RamInit     = 8'h00;
  localparam logic [DataW-1:0]   RomInit     = 8'hFF;
  localparam logic [DataW-1:0]   EmptyByte   = 8'hFF;
  localparam logic [DataW-1:0]   PrimaryInit = 8'hF0;

  localparam logic               CfgIdxCart  = 1'b0;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SLOT  = 2'd2,
    ACT_LOAD  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SLOT_SYS   = 2'd0,
    SLOT_CART  = 2'd1,
    SLOT_EMPTY = 2'd2,
    SLOT_RAM   = 2'd3
  } slot_e;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_EMPTY,
    SRC_SEC,
    SRC_SYS,
    SRC_CART,
    SRC_RAM
  } src_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

endpackage

FILE: rtl/core/slot_memory_decoder_core.sv
// Slot memory decoder: page/slot decode over main RAM, system ROM and cartridge ROM.
// After reset the block holds busy high while it walks every byte address of the
// largest store, clearing RAM to 0x00 and both ROMs to 0xFF; configuration writes are
// taken meanwhile. Then it takes one bus beat per cycle (start while busy is low) and
// returns exactly one read_data beat, strobed by read_data_valid_o, in the cycle after
// acceptance: the registered read of the store memories sets that delay.
// Results cannot be stalled; read_data is 0 for actions other than read.
module slot_memory_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [smd_pkg::AddrW-1:0]   address_i,
  input  logic [smd_pkg::DataW-1:0]   write_data_i,
  input  logic                        rom_select_i,
  output logic [smd_pkg::DataW-1:0]   read_data_o,
  output logic                        read_data_valid_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  smd_pkg::state_e                  state_q, state_d;
  logic [smd_pkg::ClrW-1:0]         clr_q, clr_d;
  logic [smd_pkg::DataW-1:0]        primary_q, primary_d;
  logic [smd_pkg::DataW-1:0]        sec_q, sec_d;
  logic                             cart_q, cart_d;
  logic                             valid_q;
  smd_pkg::src_e                    src_q, src_d;

  logic [smd_pkg::DataW-1:0]        ram_mem [smd_pkg::RamBytes];
  logic [smd_pkg::DataW-1:0]        sys_mem [smd_pkg::RomBytes];
  logic [smd_pkg::DataW-1:0]        cart_mem [smd_pkg::RomBytes];
  logic [smd_pkg::DataW-1:0]        ram_rd_q, sys_rd_q, cart_rd_q;

  logic                             ram_we, sys_we, cart_we;
  logic [smd_pkg::RamAw-1:0]        ram_waddr;
  logic [smd_pkg::RomAw-1:0]        rom_waddr;
  logic [smd_pkg::DataW-1:0]        ram_wdata, rom_wdata;

  logic                             accept, clearing, cfg_wr;
  logic                             ram_in, rom_in, is_top;
  logic [1:0]                       slot;
  smd_pkg::action_e                 act;

  assign clearing = (state_q == smd_pkg::ST_CLEAR);
  assign busy     = clearing;
  assign accept   = start & ~clearing;
  assign act      = smd_pkg::action_e'(action_i);

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & (paddr[2] == smd_pkg::CfgIdxCart);
  assign prdata   = (paddr[2] == smd_pkg::CfgIdxCart) ? {31'd0, cart_q} : 32'd0;
  assign cart_d   = cfg_wr ? pwdata[0] : cart_q;

  assign ram_in   = ({1'b0, address_i} < smd_pkg::RamLimit);
  assign rom_in   = ({1'b0, address_i} < smd_pkg::RomLimit);
  assign is_top   = (address_i == smd_pkg::SecRegAddr);

  always_comb begin
    unique case (address_i[15:14])
      2'd0:    slot = primary_q[1:0];
      2'd1:    slot = primary_q[3:2];
      2'd2:    slot = primary_q[5:4];
      default: slot = primary_q[7:6];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    primary_d = primary_q;
    sec_d     = sec_q;
    src_d     = smd_pkg::SRC_ZERO;
    ram_we    = 1'b0;
    sys_we    = 1'b0;
    cart_we   = 1'b0;
    ram_waddr = address_i[smd_pkg::RamAw-1:0];
    rom_waddr = address_i[smd_pkg::RomAw-1:0];
    ram_wdata = write_data_i;
    rom_wdata = write_data_i;
    if (clearing) begin
      ram_waddr = clr_q[smd_pkg::RamAw-1:0];
      rom_waddr = clr_q[smd_pkg::RomAw-1:0];
      ram_wdata = smd_pkg::RamInit;
      rom_wdata = smd_pkg::RomInit;
      ram_we    = ({1'b0, clr_q} < smd_pkg::RamClrLimit);
      sys_we    = ({1'b0, clr_q} < smd_pkg::RomClrLimit);
      cart_we   = sys_we;
      clr_d     = clr_q + 1'b1;
      if (clr_q == smd_pkg::ClrLast) begin
        state_d = smd_pkg::ST_RUN;
      end
    end else if (accept) begin
      unique case (act)
        smd_pkg::ACT_READ: begin
          priority if (is_top && slot == smd_pkg::SLOT_RAM) begin
            src_d = smd_pkg::SRC_SEC;
          end else if (is_top && slot == smd_pkg::SLOT_SYS) begin
            src_d = smd_pkg::SRC_ZERO;
          end else if (slot == smd_pkg::SLOT_SYS && rom_in) begin
            src_d = smd_pkg::SRC_SYS;
          end else if (slot == smd_pkg::SLOT_CART && rom_in && cart_q) begin
            src_d = smd_pkg::SRC_CART;
          end else if (slot == smd_pkg::SLOT_RAM && ram_in) begin
            src_d = smd_pkg::SRC_RAM;
          end else begin
            src_d = smd_pkg::SRC_EMPTY;
          end
        end
        smd_pkg::ACT_WRITE: begin
          if (slot == smd_pkg::SLOT_RAM) begin
            if (is_top) begin
              sec_d = write_data_i;
            end else begin
              ram_we = ram_in;
            end
          end
        end
        smd_pkg::ACT_SLOT: begin
          primary_d = write_data_i;
        end
        default: begin
          sys_we  = rom_in & ~rom_select_i;
          cart_we = rom_in & rom_select_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smd_pkg::ST_CLEAR;
      clr_q     <= '0;
      primary_q <= smd_pkg::PrimaryInit;
      sec_q     <= '0;
      cart_q    <= 1'b0;
      valid_q   <= 1'b0;
      src_q     <= smd_pkg::SRC_ZERO;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      primary_q <= primary_d;
      sec_q     <= sec_d;
      cart_q    <= cart_d;
      valid_q   <= accept;
      src_q     <= src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    ram_rd_q <= ram_mem[address_i[smd_pkg::RamAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sys_we) begin
      sys_mem[rom_waddr] <= rom_wdata;
    end
    sys_rd_q <= sys_mem[address_i[smd_pkg::RomAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cart_we) begin
      cart_mem[rom_waddr] <= rom_wdata;
    end
    cart_rd_q <= cart_mem[address_i[smd_pkg::RomAw-1:0]];
  end

  always_comb begin
    unique case (src_q)
      smd_pkg::SRC_EMPTY: read_data_o = smd_pkg::EmptyByte;
      smd_pkg::SRC_SEC:   read_data_o = ~sec_q;
      smd_pkg::SRC_SYS:   read_data_o = sys_rd_q;
      smd_pkg::SRC_CART:  read_data_o = cart_rd_q;
      smd_pkg::SRC_RAM:   read_data_o = ram_rd_q;
      default:            read_data_o = '0;
    endcase
  end

  assign read_data_valid_o = valid_q;

endmodule
